// File: hw/rtl/htd_pkg.sv
// Shared constants and types for the serial Huffman tree loader and decoder.
// No dependencies; htd_if, the top level and the checker refer to it by scoped names.
`default_nettype none

package htd_pkg;

   // Defaults of the top-level parameters.
   localparam int SymbolBits    = 8;
   localparam int NodeDepth     = 512;
   localparam int StackDepth    = 256;

   // Result channel and configuration port widths.
   localparam int OutBits       = 8;
   localparam int CsrIndexBits  = 1;
   localparam int CsrDataBits   = 8;

   // Reset values of the configuration registers.
   localparam logic                 DropEnableReset = 1'b1;
   localparam logic [OutBits-1:0]   DropCodeReset   = 8'd13;

   // Result queue entries (power of two).
   localparam int RspQueueDepth = 4;

   typedef enum logic [CsrIndexBits-1:0] {
      CsrDropEnable = 1'b0,
      CsrDropCode   = 1'b1
   } htd_csr_index_type;

endpackage

`default_nettype wire

// File: hw/rtl/htd_if.sv
// Valid/ready channel interfaces: request bits in, decoded symbols out, CSR writes.
// Depends on htd_pkg for the payload widths.
`default_nettype none

interface htd_req_if;
   logic valid;
   logic ready;
   logic func;
   logic in_bit;
   modport source (output valid, output func, output in_bit, input ready);
   modport sink   (input valid, input func, input in_bit, output ready);
endinterface

interface htd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [htd_pkg::OutBits-1:0] symbol;
   modport source (output valid, output symbol, input ready);
   modport sink   (input valid, input symbol, output ready);
endinterface

interface htd_csr_if;
   logic                             valid;
   logic                             ready;
   logic [htd_pkg::CsrIndexBits-1:0] index;
   logic [htd_pkg::CsrDataBits-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/htd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module htd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/htd_rsp_queue.sv
// Small result queue that decouples the decode stage from the result channel.
// No dependencies; DEPTH must be a power of two.
`default_nettype none

module htd_rsp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PW   = $clog2(DEPTH),
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_en,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop_en,
   output logic [WIDTH-1:0] head_data,
   output logic [CW-1:0]    count
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = push_en ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop_en  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(push_en) - CW'(pop_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

`default_nettype wire

// File: hw/rtl/huffman_tree_load_and_bit_decode.sv
// Serial Huffman decoder: rebuilds a code tree from a preorder header, then decodes bits.
// Depends on htd_pkg, htd_if (channels), htd_ram (node slots, pending stack), htd_rsp_queue.
//
// Use:
//   req_bus carries one bit per request: func = 0 is a tree header bit, func = 1 a
//   compressed data bit. Header bits build the tree (1 = internal node, 0 = leaf
//   followed by its SYMBOL_BITS-bit symbol, MSB first). Once the last leaf symbol
//   lands with no child slot pending, data bits walk the tree; each leaf reached
//   returns one symbol on rsp_bus unless it matches the drop code with dropping on.
//   csr_bus writes drop_enable (index 0) and drop_code (index 1); it is always ready.
// Timing:
//   One request per cycle while req_bus.ready is high. A symbol from an accepted data bit
//   passes the registered node-slot read and the result queue before it shows on rsp_bus.
//   The walk does one node-slot read per bit; its registered data forms the next address.
// Stalls:
//   A four-entry result queue absorbs back pressure. req_bus.ready drops only when
//   the queue plus the bit in flight would fill it; nothing is lost or repeated.
// Reset:
//   Synchronous, active high. Clears the build state (empty stack, no nodes, tree
//   not ready), the queue and the walk; drop_enable = 1, drop_code = 13. The RAMs
//   are not cleared and need no clearing pass: only written entries are read.
`default_nettype none

module huffman_tree_load_and_bit_decode #(
   parameter int SYMBOL_BITS = htd_pkg::SymbolBits,
   parameter int NODE_DEPTH  = htd_pkg::NodeDepth,
   parameter int STACK_DEPTH = htd_pkg::StackDepth
) (
   input  logic          clock,
   input  logic          reset,
   htd_req_if.sink       req_bus,
   htd_rsp_if.source     rsp_bus,
   htd_csr_if.sink       csr_bus
);

   localparam int SB  = SYMBOL_BITS;
   localparam int NB  = $clog2(NODE_DEPTH);         // node index bits
   localparam int NCB = $clog2(NODE_DEPTH + 1);     // node count bits
   localparam int SLB = NB + 1;                     // child slot = {parent, side}
   localparam int STB = $clog2(STACK_DEPTH);        // stack RAM index bits
   localparam int SCB = $clog2(STACK_DEPTH + 1);    // stack fill bits
   localparam int LCB = $clog2(SYMBOL_BITS + 1);    // symbol bit counter
   localparam int EW  = 1 + SB + NB;                // slot entry {leaf, symbol, child}
   localparam int CMW = (SB > htd_pkg::OutBits) ? SB : htd_pkg::OutBits;
   localparam int QD  = htd_pkg::RspQueueDepth;
   localparam int QCB = $clog2(QD + 1);

   typedef enum logic [3:0] {
      PhNode   = 4'b0001,
      PhSymbol = 4'b0010,
      PhDone   = 4'b0100,
      PhFailed = 4'b1000
   } htd_phase_type;

   // Build state
   htd_phase_type    phase_ff, phase_in;
   logic [NCB-1:0]   node_count_ff, node_count_in;
   logic [SCB-1:0]   stack_top_ff, stack_top_in;
   logic [SLB-1:0]   top_cache_ff, top_cache_in;   // top of the pending stack
   logic             refill_ff, refill_in;
   logic [SLB-1:0]   leaf_slot_ff, leaf_slot_in;
   logic [SB-1:0]    leaf_shift_ff, leaf_shift_in;
   logic [LCB-1:0]   leaf_cnt_ff, leaf_cnt_in;
   logic             root_leaf_ff, root_leaf_in;
   logic [SB-1:0]    root_sym_ff, root_sym_in;

   // Walk state
   logic [NB-1:0]    cur_ff, cur_in;
   logic             s1_walk_ff, s1_direct_ff;

   // Configuration
   logic                        drop_enable_ff;
   logic [htd_pkg::OutBits-1:0] drop_code_ff;

   // Memory ports
   logic             stk_wr_en, stk_rd_en;
   logic [STB-1:0]   stk_wr_addr, stk_rd_addr;
   logic [SLB-1:0]   stk_wr_data, stk_rd_data;
   logic             slot_wr_en, slot_rd_en;
   logic [SLB-1:0]   slot_wr_addr, slot_rd_addr;
   logic [EW-1:0]    slot_wr_data, slot_rd_data;

   // Handshake and decode signals
   logic             req_acc, hdr_acc, data_acc;
   logic             n_nonzero, node_fail, fail_stack;
   logic [SCB-1:0]   avail;
   logic [NB-1:0]    node_idx;
   logic [SB:0]      shift_wide;
   logic [SB-1:0]    shifted;
   logic             rd_leaf;
   logic [SB-1:0]    rd_sym;
   logic [NB-1:0]    rd_idx;
   logic [SB-1:0]    emit_sym;
   logic [CMW-1:0]   emit_wide;
   logic             emit_hit, emit_drop, push_en, pop_en;
   logic [QCB-1:0]   q_count;
   logic [htd_pkg::OutBits-1:0] q_head;

   assign req_acc  = req_bus.valid & req_bus.ready;
   assign hdr_acc  = req_acc & ~req_bus.func;
   assign data_acc = req_acc & req_bus.func & (phase_ff == PhDone);

   // Node bit checks: table full, no slot to hang on, or stack would overflow.
   assign n_nonzero  = (node_count_ff != '0);
   assign node_idx   = node_count_ff[NB-1:0];
   assign avail      = stack_top_ff - SCB'(n_nonzero);
   assign fail_stack = req_bus.in_bit &&
                       (({1'b0, avail} + (SCB+1)'(2)) > (SCB+1)'(STACK_DEPTH));
   assign node_fail  = (node_count_ff >= NCB'(NODE_DEPTH)) ||
                       (n_nonzero && (stack_top_ff == '0)) || fail_stack;

   assign shift_wide = {leaf_shift_ff, req_bus.in_bit};
   assign shifted    = shift_wide[SB-1:0];

   // Header build
   always_comb begin
      phase_in      = phase_ff;
      node_count_in = node_count_ff;
      stack_top_in  = stack_top_ff;
      top_cache_in  = refill_ff ? stk_rd_data : top_cache_ff;
      refill_in     = 1'b0;
      leaf_slot_in  = leaf_slot_ff;
      leaf_shift_in = leaf_shift_ff;
      leaf_cnt_in   = leaf_cnt_ff;
      root_leaf_in  = root_leaf_ff;
      root_sym_in   = root_sym_ff;
      stk_wr_en     = 1'b0;
      stk_wr_addr   = avail[STB-1:0];
      stk_wr_data   = {node_idx, 1'b1};
      stk_rd_en     = 1'b0;
      stk_rd_addr   = STB'(stack_top_ff - SCB'(2));
      slot_wr_en    = 1'b0;
      slot_wr_addr  = top_cache_ff;
      slot_wr_data  = {1'b0, {SB{1'b0}}, node_idx};

      if (hdr_acc) begin
         unique case (phase_ff)
            PhNode: begin
               if (node_fail) begin
                  phase_in = PhFailed;
               end else begin
                  node_count_in = node_count_ff + NCB'(1);
                  if (req_bus.in_bit) begin
                     // Internal node: hang it on the popped slot, push right then left.
                     if (n_nonzero) begin
                        slot_wr_en = 1'b1;
                     end else begin
                        root_leaf_in = 1'b0;
                     end
                     stk_wr_en    = 1'b1;
                     top_cache_in = {node_idx, 1'b0};
                     stack_top_in = avail + SCB'(2);
                  end else begin
                     // Leaf: remember its slot; refill the cached top from the RAM.
                     if (n_nonzero) begin
                        leaf_slot_in = top_cache_ff;
                        stack_top_in = stack_top_ff - SCB'(1);
                        if (stack_top_ff >= SCB'(2)) begin
                           stk_rd_en = 1'b1;
                           refill_in = 1'b1;
                        end
                     end else begin
                        root_leaf_in = 1'b1;
                     end
                     phase_in    = PhSymbol;
                     leaf_cnt_in = '0;
                  end
               end
            end
            PhSymbol: begin
               leaf_shift_in = shifted;
               if (leaf_cnt_ff == LCB'(SB - 1)) begin
                  leaf_cnt_in = '0;
                  if (node_count_ff == NCB'(1)) begin
                     root_sym_in = shifted;
                  end else begin
                     slot_wr_en   = 1'b1;
                     slot_wr_addr = leaf_slot_ff;
                     slot_wr_data = {1'b1, shifted, {NB{1'b0}}};
                  end
                  phase_in = (stack_top_ff == '0) ? PhDone : PhNode;
               end else begin
                  leaf_cnt_in = leaf_cnt_ff + LCB'(1);
               end
            end
            PhDone, PhFailed: begin
               // hold: header bits are ignored here
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Tree walk: the child entry of the last bit arrives as registered RAM data.
   assign rd_leaf = slot_rd_data[EW-1];
   assign rd_sym  = slot_rd_data[EW-2:NB];
   assign rd_idx  = slot_rd_data[NB-1:0];

   always_comb begin
      cur_in       = s1_walk_ff ? (rd_leaf ? '0 : rd_idx) : cur_ff;
      slot_rd_en   = data_acc & ~root_leaf_ff;
      slot_rd_addr = {cur_in, req_bus.in_bit};
   end

   // Emit stage: leaf reached or single-leaf tree, then the drop test.
   always_comb begin
      emit_sym  = s1_direct_ff ? root_sym_ff : rd_sym;
      emit_hit  = s1_direct_ff | (s1_walk_ff & rd_leaf);
      emit_wide = CMW'(emit_sym);
      emit_drop = drop_enable_ff && (emit_wide == CMW'(drop_code_ff));
      push_en   = emit_hit & ~emit_drop;
      pop_en    = rsp_bus.valid & rsp_bus.ready;
   end

   // Accept while the queue has room for everything already in flight.
   assign req_bus.ready = ((QCB+1)'(q_count) + (QCB+1)'(s1_walk_ff | s1_direct_ff))
                          < (QCB+1)'(QD);
   assign rsp_bus.valid  = (q_count != '0);
   assign rsp_bus.symbol = q_head;
   assign csr_bus.ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PhNode;
         node_count_ff  <= '0;
         stack_top_ff   <= '0;
         refill_ff      <= 1'b0;
         leaf_cnt_ff    <= '0;
         cur_ff         <= '0;
         s1_walk_ff     <= 1'b0;
         s1_direct_ff   <= 1'b0;
         drop_enable_ff <= htd_pkg::DropEnableReset;
         drop_code_ff   <= htd_pkg::DropCodeReset;
      end else begin
         phase_ff      <= phase_in;
         node_count_ff <= node_count_in;
         stack_top_ff  <= stack_top_in;
         refill_ff     <= refill_in;
         leaf_cnt_ff   <= leaf_cnt_in;
         cur_ff        <= cur_in;
         s1_walk_ff    <= data_acc & ~root_leaf_ff;
         s1_direct_ff  <= data_acc & root_leaf_ff;
         if (csr_bus.valid) begin
            if (csr_bus.index == htd_pkg::CsrDropEnable) begin
               drop_enable_ff <= csr_bus.data[0];
            end
            if (csr_bus.index == htd_pkg::CsrDropCode) begin
               drop_code_ff <= csr_bus.data;
            end
         end
      end
   end

   // Payload registers: only read once the build state says they are valid.
   always_ff @(posedge clock) begin
      top_cache_ff  <= top_cache_in;
      leaf_slot_ff  <= leaf_slot_in;
      leaf_shift_ff <= leaf_shift_in;
      root_leaf_ff  <= root_leaf_in;
      root_sym_ff   <= root_sym_in;
   end

   // Child slots: entry {parent, side} holds the child's leaf flag, symbol and index.
   htd_ram #(
      .WIDTH (EW),
      .DEPTH (2 * NODE_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   // Pending child slots below the cached top.
   htd_ram #(
      .WIDTH (SLB),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   htd_rsp_queue #(
      .WIDTH (htd_pkg::OutBits),
      .DEPTH (QD)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (push_en),
      .push_data (emit_wide[htd_pkg::OutBits-1:0]),
      .pop_en    (pop_en),
      .head_data (q_head),
      .count     (q_count)
   );

endmodule

`default_nettype wire

// File: hw/rtl/htd_checker.sv
// Port-level checks for the serial Huffman decoder, bound to the top level.
// Depends on htd_pkg and on the top level's channel ports.
`default_nettype none

module htd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_func,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [htd_pkg::OutBits-1:0] rsp_symbol
);

   logic req_acc;
   assign req_acc = req_valid & req_ready;

   // A stalled symbol holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_symbol))
      else $error("stalled symbol changed or vanished");

   // Reset empties the result side and opens the request side.
   assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("reset left a result pending or requests blocked");

   // A symbol appearing on an empty channel comes from an accepted data bit, via the walk stage and the queue.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_acc && req_func, 2))
      else $error("symbol without a matching data bit");

   // With no request in flight and an empty channel, nothing appears.
   assert property (@(posedge clock) disable iff (reset)
      !req_acc ##1 !req_acc ##1 !rsp_valid |=> !rsp_valid)
      else $error("symbol appeared with no request in flight");

endmodule

bind huffman_tree_load_and_bit_decode htd_checker u_htd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .req_func   (req_bus.func),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_symbol (rsp_bus.symbol)
);

`default_nettype wire
